// ----- design/cls_pkg.sv -----
// shared types and constants for the compacting list store
package cls_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int WORD_W   = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         index_t;
  typedef logic [CNT_W-1:0]         count_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;
  } dp_ctrl_t;

endpackage

// ----- design/cls_if.sv -----
// request and response channel interfaces
interface cls_req_if;
  import cls_pkg::*;
  logic   valid;
  logic   ready;
  cmd_t   command;
  word_t  value;
  index_t index;

  modport source (output valid, output command, output value, output index, input ready);
  modport sink   (input valid, input command, input value, input index, output ready);
endinterface

interface cls_rsp_if;
  import cls_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  word_t   data_out;
  count_t  count_out;

  modport source (output valid, output status, output data_out, output count_out, input ready);
  modport sink   (input valid, input status, input data_out, input count_out, output ready);
endinterface

// ----- design/cls_ctrl.sv -----
// handshake controller: tracks whether a response is held
module cls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cls_pkg::dp_ctrl_t ctrl
);
  import cls_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // a new request may enter when the response slot is free or draining
  assign req_ready = (state == S_IDLE) || rsp_ready;
  assign rsp_valid = (state == S_HOLD);
  assign ctrl.exec = req_valid && req_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctrl.exec) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (ctrl.exec) state_next = S_HOLD;
        else if (rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ----- design/cls_datapath.sv -----
// entry cells, count register and response registers
module cls_datapath (
  input  logic              clk,
  input  logic              rst,
  input  cls_pkg::dp_ctrl_t ctrl,
  input  cls_pkg::cmd_t     command,
  input  cls_pkg::word_t    value,
  input  cls_pkg::index_t   index,
  output cls_pkg::status_t  status,
  output cls_pkg::word_t    data_out,
  output cls_pkg::count_t   count_out
);
  import cls_pkg::*;

  word_t   entries [CAPACITY];
  count_t  count;
  count_t  count_next;
  status_t status_next;
  word_t   data_next;
  logic    idx_ok;
  logic    full;
  logic    do_append;
  logic    do_remove;
  word_t   rd_word;

  assign idx_ok  = {{(CNT_W-IDX_W){1'b0}}, index} < count;
  assign full    = (count == count_t'(CAPACITY));
  assign rd_word = entries[index];

  // decode the request
  always_comb begin
    do_append   = 1'b0;
    do_remove   = 1'b0;
    count_next  = count;
    status_next = ST_DONE;
    data_next   = '0;
    unique case (command)
      CMD_APPEND: begin
        if (full) status_next = ST_FULL;
        else begin
          do_append  = 1'b1;
          count_next = count + count_t'(1);
        end
      end
      CMD_REMOVE: begin
        if (!idx_ok) status_next = ST_INVALID;
        else begin
          do_remove  = 1'b1;
          data_next  = rd_word;
          count_next = count - count_t'(1);
        end
      end
      CMD_READ: begin
        if (!idx_ok) status_next = ST_INVALID;
        else data_next = rd_word;
      end
      default: begin
      end
    endcase
  end

  // entry cells: append writes at the tail, remove shifts later cells down
  always_ff @(posedge clk) begin
    if (ctrl.exec && do_append) entries[count[IDX_W-1:0]] <= value;
    for (int i = 0; i < CAPACITY - 1; i++) begin
      if (ctrl.exec && do_remove && (index_t'(i) >= index)) entries[i] <= entries[i + 1];
    end
  end

  // count register
  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (ctrl.exec) count <= count_next;
  end

  // response registers
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      status   <= status_next;
      data_out <= data_next;
    end
  end

  assign count_out = count;

endmodule

// ----- design/compacting_list_store.sv -----
// top level: bounded list of signed words with compaction on remove
// the response is valid in the cycle after its request is accepted
// throughput: one request per cycle while responses are taken; the response register frees as it is taken
// every command, including remove with its shift, completes on the clock edge that accepts it
// reset (synchronous, active high) empties the list and drops any held response
module compacting_list_store (
  input  logic      clk,
  input  logic      rst,
  cls_req_if.sink   req,
  cls_rsp_if.source rsp
);
  import cls_pkg::*;

  dp_ctrl_t ctrl;

  cls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctrl      (ctrl)
  );

  cls_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .command   (req.command),
    .value     (req.value),
    .index     (req.index),
    .status    (rsp.status),
    .data_out  (rsp.data_out),
    .count_out (rsp.count_out)
  );

endmodule

// ----- tb/tb_compacting_list_store.sv -----
// testbench for the compacting list store: directed table, then random requests
`timescale 1ns / 100ps

module tb_compacting_list_store;
  import cls_pkg::*;

  localparam int RANDOM_ITEMS    = 1750;
  localparam int HOLD_AT         = 400;
  localparam int PAUSE_AT        = 900;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int REPORT_LIMIT    = 100;
  localparam int DIR_ROWS        = 20;

  // one response as the block reports it
  typedef struct packed {
    status_t status;
    word_t   data;
    count_t  count;
  } list_rsp_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct {
    cmd_t      cmd;
    word_t     value;
    index_t    index;
    int        reps;
    bit        typed;
    list_rsp_t want;
  } list_step_t;

  logic clk;
  logic rst;

  cls_req_if req_ch ();
  cls_rsp_if rsp_ch ();

  compacting_list_store dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predicted contents of the list
  word_t     list_words [CAPACITY];
  int        list_count = 0;
  list_rsp_t expected_rsps [$];
  list_step_t dir_steps [DIR_ROWS];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  bit rsp_hold_req   = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // reset held from the start, released on a falling edge
  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // apply one command to the predicted list and return its response
  function automatic list_rsp_t apply_list_cmd(cmd_t cmd, word_t value, index_t index);
    list_rsp_t r;
    int i;
    r.status = ST_DONE;
    r.data   = '0;
    case (cmd)
      CMD_APPEND: begin
        if (list_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_count] = value;
          list_count++;
        end
      end
      CMD_REMOVE: begin
        if (int'(index) >= list_count) begin
          r.status = ST_INVALID;
        end else begin
          r.data = list_words[index];
          for (i = int'(index); i + 1 < list_count; i++) list_words[i] = list_words[i + 1];
          list_count--;
        end
      end
      CMD_READ: begin
        if (int'(index) >= list_count) r.status = ST_INVALID;
        else r.data = list_words[index];
      end
      default: ;
    endcase
    r.count = count_t'(list_count);
    return r;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // offer one request, wait for it to be taken, record its expected response
  task automatic send_list_cmd(cmd_t cmd, word_t value, index_t index, bit typed,
                               list_rsp_t want);
    list_rsp_t predicted;
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.value   <= value;
    req_ch.index   <= index;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_list_cmd(cmd, value, index);
    expected_rsps.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // idle the request side for a random number of cycles
  task automatic pace_sender(bit no_gap);
    int gap;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // request side: directed table, then random traffic
  initial begin
    int k;
    int r;
    int mode_left;
    bit fill_mode;
    cmd_t cmd;
    word_t val;
    index_t idx;

    req_ch.valid   <= 1'b0;
    req_ch.command <= CMD_NOP;
    req_ch.value   <= '0;
    req_ch.index   <= '0;

    dir_steps = '{
      '{CMD_READ,   32'sh0,         4'd0,  1, 1'b1, '{ST_INVALID, 32'sh0, 5'd0}},
      '{CMD_REMOVE, 32'sh0,         4'd15, 1, 1'b1, '{ST_INVALID, 32'sh0, 5'd0}},
      '{CMD_NOP,    -32'sd1,        4'd15, 1, 1'b1, '{ST_DONE, 32'sh0, 5'd0}},
      '{CMD_APPEND, 32'sh7FFFFFFF,  4'd0,  1, 1'b1, '{ST_DONE, 32'sh0, 5'd1}},
      '{CMD_APPEND, 32'sh80000000,  4'd15, 1, 1'b1, '{ST_DONE, 32'sh0, 5'd2}},
      '{CMD_READ,   32'sh0,         4'd0,  1, 1'b1, '{ST_DONE, 32'sh7FFFFFFF, 5'd2}},
      '{CMD_READ,   32'sh0,         4'd1,  1, 1'b1, '{ST_DONE, 32'sh80000000, 5'd2}},
      '{CMD_READ,   32'sh0,         4'd2,  1, 1'b1, '{ST_INVALID, 32'sh0, 5'd2}},
      // fill the rest of the list with distinct words
      '{CMD_APPEND, 32'sh12340000,  4'd0, 14, 1'b0, '0},
      '{CMD_APPEND, 32'sh5555AAAA,  4'd0,  1, 1'b1, '{ST_FULL, 32'sh0, 5'd16}},
      '{CMD_READ,   32'sh0,         4'd15, 1, 1'b1, '{ST_DONE, 32'sh1234000D, 5'd16}},
      '{CMD_REMOVE, 32'sh0,         4'd0,  1, 1'b1, '{ST_DONE, 32'sh7FFFFFFF, 5'd15}},
      '{CMD_REMOVE, 32'sh0,         4'd14, 1, 1'b1, '{ST_DONE, 32'sh1234000D, 5'd14}},
      '{CMD_REMOVE, 32'sh0,         4'd14, 1, 1'b1, '{ST_INVALID, 32'sh0, 5'd14}},
      '{CMD_READ,   32'sh0,         4'd0,  1, 1'b1, '{ST_DONE, 32'sh80000000, 5'd14}},
      // remove from the middle, then look at the word shifted in
      '{CMD_REMOVE, 32'sh0,         4'd5,  1, 1'b0, '0},
      '{CMD_READ,   32'sh0,         4'd5,  1, 1'b0, '0},
      '{CMD_NOP,    32'sh0,         4'd0,  1, 1'b1, '{ST_DONE, 32'sh0, 5'd13}},
      '{CMD_REMOVE, 32'sh0,         4'd13, 1, 1'b1, '{ST_INVALID, 32'sh0, 5'd13}},
      '{CMD_REMOVE, -32'sd1,        4'd12, 1, 1'b0, '0}
    };

    while (rst) @(negedge clk);

    // directed table
    for (int s = 0; s < DIR_ROWS; s++) begin
      for (int j = 0; j < dir_steps[s].reps; j++) begin
        send_list_cmd(dir_steps[s].cmd, dir_steps[s].value + word_t'(j), dir_steps[s].index,
                      dir_steps[s].typed, dir_steps[s].want);
        pace_sender(1'b0);
      end
    end

    // random traffic in alternating fill and drain phases
    fill_mode = 1'b1;
    mode_left = $urandom_range(20, 80);
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (mode_left == 0) begin
        fill_mode = !fill_mode;
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;

      r = $urandom_range(0, 99);
      if (r < 5) cmd = CMD_NOP;
      else if (fill_mode) cmd = (r < 65) ? CMD_APPEND : (r < 80) ? CMD_REMOVE : CMD_READ;
      else cmd = (r < 20) ? CMD_APPEND : (r < 70) ? CMD_REMOVE : CMD_READ;

      r = $urandom_range(0, 99);
      if (r < 3) val = 32'sh7FFFFFFF;
      else if (r < 6) val = 32'sh80000000;
      else if (r < 8) val = '0;
      else if (r < 10) val = -32'sd1;
      else val = word_t'($urandom);

      if (list_count > 0 && $urandom_range(0, 99) < 85)
        idx = index_t'($urandom_range(0, list_count - 1));
      else
        idx = index_t'($urandom_range(0, 15));

      // long response stall while requests keep coming
      if (k == HOLD_AT) rsp_hold_req = 1'b1;

      send_list_cmd(cmd, val, idx, 1'b0, '0);

      // pause until every response is back, otherwise random gaps except in no-gap stretches
      if (k == PAUSE_AT) begin
        req_ch.valid <= 1'b0;
        while (expected_rsps.size() != 0) @(negedge clk);
        @(negedge clk);
      end else begin
        pace_sender((k % 200) < 60 || (k >= HOLD_AT && k < HOLD_AT + 20));
      end
    end

    // let the last responses drain
    req_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // response side: runs of ready and idle, plus a long hold on request
  initial begin
    int run_left;
    bit run_ready;
    run_left  = 0;
    run_ready = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(negedge clk);
        rsp_hold_req = 1'b0;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          run_ready = !run_ready;
          if (run_ready)
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 12);
          else
            run_left = gap_len() + 1;
        end
        rsp_ch.ready <= run_ready;
        run_left--;
      end
    end
  end

  // field compare with a cap on printed reports
  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endfunction

  // compare each taken response with the oldest expectation
  always @(posedge clk) begin
    list_rsp_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_rsps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected response, expected none, got status %0d data %h count %0d",
                   $time, rsp_ch.status, rsp_ch.data_out, rsp_ch.count_out);
      end else begin
        want = expected_rsps.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_ch.status));
        check_field("data_out", want.data, rsp_ch.data_out);
        check_field("count_out", 32'(want.count), 32'(rsp_ch.count_out));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
